[sv/mmra_pkg.sv]
// package: request and report types, operation codes and constants of the motion accumulator
`timescale 1ns / 1ps
`default_nettype none

package mmra_pkg;

  localparam int unsigned SumWidth    = 32;
  localparam int unsigned DeltaWidth  = 16;
  localparam int unsigned ButtonWidth = 8;
  localparam int unsigned LenWidth    = 6;

  // only packets of this many payload bytes carry motion
  localparam logic [LenWidth-1:0] PacketLength = LenWidth'(6);

  typedef enum logic [1:0] {
    OP_RECEIVE      = 2'd0,
    OP_COMMIT       = 2'd1,
    OP_TAKE_WAKEUP  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]                    operation;
    logic [LenWidth-1:0]           pkt_length;
    logic [ButtonWidth-1:0]        button_bits;
    logic signed [DeltaWidth-1:0]  delta_x;
    logic signed [DeltaWidth-1:0]  delta_y;
  } req_t;

  typedef struct packed {
    logic                          report_valid;
    logic [ButtonWidth-1:0]        report_buttons;
    logic signed [DeltaWidth-1:0]  report_x;
    logic signed [DeltaWidth-1:0]  report_y;
    logic                          wakeup_taken;
    logic                          packet_dropped;
  } rsp_t;

  typedef struct packed {
    logic signed [SumWidth-1:0]    x_sum;
    logic signed [SumWidth-1:0]    y_sum;
    logic [ButtonWidth-1:0]        buttons;
    logic                          changed;
    logic                          wakeup;
  } state_t;

endpackage

`default_nettype wire

[sv/mmra_sat_acc.sv]
// saturating 32-bit add or subtract of a signed 16-bit delta, plus 16-bit clamp of the result
`timescale 1ns / 1ps
`default_nettype none

module mmra_sat_acc (
  input  wire logic signed [mmra_pkg::SumWidth-1:0]   sum_i,
  input  wire logic signed [mmra_pkg::DeltaWidth-1:0] delta_i,
  input  wire logic                                   sub_i,
  output logic signed [mmra_pkg::SumWidth-1:0]        sum_o,
  output logic signed [mmra_pkg::DeltaWidth-1:0]      clamp_o
);

  localparam int unsigned SW = mmra_pkg::SumWidth;
  localparam int unsigned DW = mmra_pkg::DeltaWidth;

  logic signed [SW:0] operand;
  logic signed [SW:0] wide;
  logic               ovf;
  logic               fits;

  always_comb begin
    operand = (SW + 1)'(delta_i);
    if (sub_i) begin
      operand = -operand;
    end
    wide = {sum_i[SW-1], sum_i} + operand;
    ovf  = wide[SW] ^ wide[SW-1];
    if (ovf) begin
      sum_o = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_o = wide[SW-1:0];
    end
  end

  // fits when all bits above the 16-bit sign agree
  assign fits = (sum_o[SW-1:DW-1] == '0) || (sum_o[SW-1:DW-1] == '1);

  always_comb begin
    if (fits) begin
      clamp_o = sum_o[DW-1:0];
    end else begin
      clamp_o = sum_o[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[sv/mmra_update.sv]
// next-state and report logic for one request
`timescale 1ns / 1ps
`default_nettype none

module mmra_update (
  input  wire mmra_pkg::req_t   req_i,
  input  wire mmra_pkg::state_t state_i,
  output mmra_pkg::state_t      state_o,
  output mmra_pkg::rsp_t        rsp_o
);

  logic                                   do_acc;
  logic                                   do_sub;
  logic                                   dropped;
  logic                                   taken;
  logic [mmra_pkg::ButtonWidth-1:0]       pressed;
  logic signed [mmra_pkg::SumWidth-1:0]   x_next;
  logic signed [mmra_pkg::SumWidth-1:0]   y_next;
  logic signed [mmra_pkg::DeltaWidth-1:0] x_clamp;
  logic signed [mmra_pkg::DeltaWidth-1:0] y_clamp;

  function automatic logic signed [mmra_pkg::DeltaWidth-1:0] clamp16(
    input logic signed [mmra_pkg::SumWidth-1:0] v
  );
    logic ok;
    ok = (v[mmra_pkg::SumWidth-1:mmra_pkg::DeltaWidth-1] == '0) ||
         (v[mmra_pkg::SumWidth-1:mmra_pkg::DeltaWidth-1] == '1);
    if (ok) begin
      return v[mmra_pkg::DeltaWidth-1:0];
    end
    return v[mmra_pkg::SumWidth-1] ? {1'b1, {(mmra_pkg::DeltaWidth-1){1'b0}}}
                                   : {1'b0, {(mmra_pkg::DeltaWidth-1){1'b1}}};
  endfunction

  mmra_sat_acc u_acc_x (
    .sum_i   (state_i.x_sum),
    .delta_i (req_i.delta_x),
    .sub_i   (do_sub),
    .sum_o   (x_next),
    .clamp_o (x_clamp)
  );

  mmra_sat_acc u_acc_y (
    .sum_i   (state_i.y_sum),
    .delta_i (req_i.delta_y),
    .sub_i   (do_sub),
    .sum_o   (y_next),
    .clamp_o (y_clamp)
  );

  assign pressed = req_i.button_bits & ~state_i.buttons;

  always_comb begin
    do_acc  = 1'b0;
    do_sub  = 1'b0;
    dropped = 1'b0;
    taken   = 1'b0;
    state_o = state_i;
    case (mmra_pkg::op_e'(req_i.operation))
      mmra_pkg::OP_RECEIVE: begin
        if (req_i.pkt_length != mmra_pkg::PacketLength) begin
          dropped = 1'b1;
        end else begin
          do_acc = 1'b1;
          if (req_i.button_bits != state_i.buttons) begin
            state_o.buttons = req_i.button_bits;
            state_o.changed = 1'b1;
            if (pressed != '0) begin
              state_o.wakeup = 1'b1;
            end
          end
        end
      end
      mmra_pkg::OP_COMMIT: begin
        do_acc = 1'b1;
        do_sub = 1'b1;
        if (req_i.button_bits == state_i.buttons) begin
          state_o.changed = 1'b0;
        end
      end
      mmra_pkg::OP_TAKE_WAKEUP: begin
        taken          = state_i.wakeup;
        state_o.wakeup = 1'b0;
      end
      default: begin
      end
    endcase
    if (do_acc) begin
      state_o.x_sum = x_next;
      state_o.y_sum = y_next;
    end
  end

  // snapshot after the request; clamp of the unchanged sum when nothing was added
  always_comb begin
    rsp_o.report_valid   = (state_o.x_sum != '0) || (state_o.y_sum != '0) || state_o.changed;
    rsp_o.report_buttons = state_o.buttons;
    rsp_o.report_x       = do_acc ? x_clamp : clamp16(state_i.x_sum);
    rsp_o.report_y       = do_acc ? y_clamp : clamp16(state_i.y_sum);
    rsp_o.wakeup_taken   = taken;
    rsp_o.packet_dropped = dropped;
  end

endmodule

`default_nettype wire

[sv/mouse_motion_report_accumulator.sv]
// top level: request register, accumulator state and report register
//
//   channel | valid       | stall       | payload            | direction
//   --------+-------------+-------------+--------------------+----------
//   request | req_valid_i | req_stall_o | req_i (req_t)      | in
//   report  | rsp_valid_o | rsp_stall_i | rsp_o (rsp_t)      | out
//
// one request per cycle sustained while reports are not stalled; a request taken into
// the request register is processed from there and registered in the report register
// the update of sums, buttons, changed mark and wakeup flag is combinational, with one
// saturating adder per axis between the request register and the report register
// reset clears the sums, buttons, marks and both valid flags; no clearing pass
// a stalled report holds; the request register still fills behind it,
// and only then does req_stall_o rise
`timescale 1ns / 1ps
`default_nettype none

module mouse_motion_report_accumulator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire mmra_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output mmra_pkg::rsp_t      rsp_o
);

  // request register
  logic             in_valid_q;
  mmra_pkg::req_t   in_q;

  // accumulator state
  mmra_pkg::state_t state_q;
  mmra_pkg::state_t state_d;

  // report register
  logic             out_valid_q;
  mmra_pkg::rsp_t   out_q;
  mmra_pkg::rsp_t   out_d;

  logic             out_ready;
  logic             advance;
  logic             req_take;

  // report slot frees when empty or being taken this cycle
  assign out_ready = !out_valid_q || !rsp_stall_i;
  // the request in the register is processed and moves into the report slot
  assign advance   = in_valid_q && out_ready;
  // request register can load when empty or emptying
  assign req_stall_o = in_valid_q && !out_ready;
  assign req_take    = req_valid_i && !req_stall_o;

  mmra_update u_update (
    .req_i   (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .rsp_o   (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_q <= req_i;
    end
  end

  // state commits only when the request actually moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

`default_nettype wire

[sv/mmra_checker.sv]
// port-level checker for the motion accumulator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mmra_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           req_valid_i,
  input wire logic           req_stall_o,
  input wire logic           rsp_valid_o,
  input wire logic           rsp_stall_i,
  input wire mmra_pkg::rsp_t rsp_o
);

  // a stalled report stays valid
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o)
    else $error("report dropped while stalled");

  // an accepted request into an empty report slot shows up as a valid report after the request and report registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o && !rsp_valid_o |-> ##2 rsp_valid_o)
    else $error("request lost in pipeline");

  // an invalid snapshot means both sums are zero
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.report_valid |-> rsp_o.report_x == '0 && rsp_o.report_y == '0)
    else $error("invalid snapshot with motion");

  // a report is either a take, a drop, or neither
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.wakeup_taken && rsp_o.packet_dropped))
    else $error("take and drop both set");

endmodule

bind mouse_motion_report_accumulator mmra_checker u_mmra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_stall_o (req_stall_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_o       (rsp_o)
);

`default_nettype wire

[dv/tb.sv]
// testbench: motion accumulator checked against an in-bench predictor over random and directed requests
`timescale 1ns / 1ps

module tb;

  // operation code outside op_e: the block must leave its state alone
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic signed [mmra_pkg::DeltaWidth-1:0] DeltaMax = 16'sh7fff;
  localparam logic signed [mmra_pkg::DeltaWidth-1:0] DeltaMin = 16'sh8000;
  localparam longint SumMax = 64'sd2147483647;
  localparam longint SumMin = -64'sd2147483648;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  mmra_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  mmra_pkg::rsp_t rsp_o;

  mouse_motion_report_accumulator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // idle percentages for the sender and the receiver, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // predictor state, mirrors the block after every accepted request
  longint acc_x_sum = 0;
  longint acc_y_sum = 0;
  logic [mmra_pkg::ButtonWidth-1:0] acc_buttons = '0;
  logic acc_changed = 1'b0;
  logic acc_wakeup = 1'b0;
  mmra_pkg::rsp_t last_report = '0;

  mmra_pkg::rsp_t expected_reports[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned drops_seen = 0;
  int unsigned wakeups_seen = 0;
  int unsigned saturations_seen = 0;
  int unsigned idle_cycles = 0;

  function automatic longint saturate_sum(input longint v);
    if (v > SumMax) begin
      saturations_seen++;
      return SumMax;
    end
    if (v < SumMin) begin
      saturations_seen++;
      return SumMin;
    end
    return v;
  endfunction

  function automatic logic signed [mmra_pkg::DeltaWidth-1:0] clamp_axis(input longint v);
    if (v > 32767) return DeltaMax;
    if (v < -32768) return DeltaMin;
    return v[mmra_pkg::DeltaWidth-1:0];
  endfunction

  // advances the predictor by one request and returns the report it must produce
  function automatic mmra_pkg::rsp_t predict_report(input mmra_pkg::req_t r);
    mmra_pkg::rsp_t rep;
    logic [mmra_pkg::ButtonWidth-1:0] pressed;
    longint dx;
    longint dy;
    rep = '0;
    dx = longint'($signed(r.delta_x));
    dy = longint'($signed(r.delta_y));
    case (r.operation)
      mmra_pkg::OP_RECEIVE: begin
        if (r.pkt_length != mmra_pkg::PacketLength) begin
          rep.packet_dropped = 1'b1;
          drops_seen++;
        end else begin
          if (r.button_bits != acc_buttons) begin
            pressed = r.button_bits & ~acc_buttons;
            acc_buttons = r.button_bits;
            acc_changed = 1'b1;
            if (pressed != '0) acc_wakeup = 1'b1;
          end
          acc_x_sum = saturate_sum(acc_x_sum + dx);
          acc_y_sum = saturate_sum(acc_y_sum + dy);
        end
      end
      mmra_pkg::OP_COMMIT: begin
        acc_x_sum = saturate_sum(acc_x_sum - dx);
        acc_y_sum = saturate_sum(acc_y_sum - dy);
        if (acc_buttons == r.button_bits) acc_changed = 1'b0;
      end
      mmra_pkg::OP_TAKE_WAKEUP: begin
        rep.wakeup_taken = acc_wakeup;
        if (acc_wakeup) wakeups_seen++;
        acc_wakeup = 1'b0;
      end
      default: ;
    endcase
    rep.report_valid = (acc_x_sum != 0) || (acc_y_sum != 0) || acc_changed;
    rep.report_buttons = acc_buttons;
    rep.report_x = clamp_axis(acc_x_sum);
    rep.report_y = clamp_axis(acc_y_sum);
    last_report = rep;
    return rep;
  endfunction

  function automatic mmra_pkg::req_t make_req(input logic [1:0] op,
                                              input logic [mmra_pkg::LenWidth-1:0] len,
                                              input logic [mmra_pkg::ButtonWidth-1:0] btn,
                                              input logic signed [mmra_pkg::DeltaWidth-1:0] dx,
                                              input logic signed [mmra_pkg::DeltaWidth-1:0] dy);
    mmra_pkg::req_t r;
    r.operation = op;
    r.pkt_length = len;
    r.button_bits = btn;
    r.delta_x = dx;
    r.delta_y = dy;
    return r;
  endfunction

  // one request over the valid/stall handshake, predicted at the edge it is taken
  task automatic send_request(input mmra_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    expected_reports.push_back(predict_report(r));
    requests_sent++;
  endtask

  function automatic logic signed [mmra_pkg::DeltaWidth-1:0] random_delta();
    int unsigned raw;
    raw = $urandom;
    if ($urandom_range(99) < 70) raw = $urandom_range(255) - 32'd128;
    return raw[mmra_pkg::DeltaWidth-1:0];
  endfunction

  // mostly well-formed traffic: packets, commits of the current report, wakeup takes
  function automatic mmra_pkg::req_t random_request();
    mmra_pkg::req_t r;
    logic [63:0] raw;
    int unsigned pick;
    raw = {$urandom, $urandom};
    r = raw[$bits(mmra_pkg::req_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.operation = mmra_pkg::OP_RECEIVE;
      r.pkt_length = mmra_pkg::PacketLength;
      case ($urandom_range(2))
        0: r.button_bits = last_report.report_buttons;
        1: r.button_bits = last_report.report_buttons ^ (8'h01 << $urandom_range(7));
        default: r.button_bits = 8'($urandom);
      endcase
      r.delta_x = random_delta();
      r.delta_y = random_delta();
    end else if (pick < 70) begin
      r.operation = mmra_pkg::OP_COMMIT;
      if ($urandom_range(99) < 80) begin
        r.button_bits = last_report.report_buttons;
        r.delta_x = last_report.report_x;
        r.delta_y = last_report.report_y;
      end else begin
        r.delta_x = random_delta();
        r.delta_y = random_delta();
      end
    end else if (pick < 80) begin
      r.operation = mmra_pkg::OP_TAKE_WAKEUP;
    end
    // the rest stays as raw noise: any opcode, any length, any fields
    return r;
  endfunction

  task automatic check_field(input string field, input longint exp_val, input longint act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  // report checker: compares every taken report against the oldest prediction
  always @(posedge clk_i) begin
    mmra_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected report, expected none, actual %h", $time, rsp_o);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("report_valid", want.report_valid, rsp_o.report_valid);
        check_field("report_buttons", want.report_buttons, rsp_o.report_buttons);
        check_field("report_x", $signed(want.report_x), $signed(rsp_o.report_x));
        check_field("report_y", $signed(want.report_y), $signed(rsp_o.report_y));
        check_field("wakeup_taken", want.wakeup_taken, rsp_o.wakeup_taken);
        check_field("packet_dropped", want.packet_dropped, rsp_o.packet_dropped);
        reports_checked++;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    rsp_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: any cycle with neither channel moving counts toward the limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t ns: no handshake for %0d cycles, %0d reports outstanding",
                 $time, idle_cycles, expected_reports.size());
        $display("mouse_motion_report_accumulator regression: fail");
        $finish;
      end
    end
  end

  task automatic test_length_filter();
    send_request(make_req(mmra_pkg::OP_TAKE_WAKEUP, '0, '0, '0, '0));
    send_request(make_req(mmra_pkg::OP_RECEIVE, 6'd0, 8'hff, DeltaMax, DeltaMin));
    send_request(make_req(mmra_pkg::OP_RECEIVE, 6'd63, 8'hff, DeltaMin, DeltaMax));
    send_request(make_req(mmra_pkg::OP_RECEIVE, 6'd5, 8'h01, 16'sd1, 16'sd1));
    send_request(make_req(mmra_pkg::OP_RECEIVE, 6'd7, 8'h80, -16'sd1, -16'sd1));
  endtask

  task automatic test_buttons_and_wakeup();
    send_request(make_req(mmra_pkg::OP_RECEIVE, mmra_pkg::PacketLength, 8'hff, '0, '0));
    send_request(make_req(mmra_pkg::OP_TAKE_WAKEUP, 6'd63, 8'h55, DeltaMax, DeltaMin));
    send_request(make_req(mmra_pkg::OP_TAKE_WAKEUP, '0, '0, '0, '0));
    // release only: changed mark set, no wakeup
    send_request(make_req(mmra_pkg::OP_RECEIVE, mmra_pkg::PacketLength, 8'h0f, '0, '0));
    send_request(make_req(mmra_pkg::OP_TAKE_WAKEUP, '0, '0, '0, '0));
    // commit with other buttons leaves the changed mark
    send_request(make_req(mmra_pkg::OP_COMMIT, 6'd6, 8'hf0, '0, '0));
    send_request(make_req(mmra_pkg::OP_COMMIT, 6'd41, 8'h0f, '0, '0));
    send_request(make_req(mmra_pkg::OP_RECEIVE, mmra_pkg::PacketLength, 8'h0f, '0, '0));
  endtask

  task automatic test_commit_and_clamp();
    send_request(make_req(mmra_pkg::OP_RECEIVE, mmra_pkg::PacketLength, 8'h0f,
                          DeltaMax, DeltaMin));
    send_request(make_req(mmra_pkg::OP_RECEIVE, mmra_pkg::PacketLength, 8'h0f,
                          DeltaMax, DeltaMin));
    send_request(make_req(mmra_pkg::OP_COMMIT, '0, 8'h0f, DeltaMax, DeltaMin));
    send_request(make_req(mmra_pkg::OP_COMMIT, 6'd63, 8'h0f, DeltaMax, DeltaMin));
    send_request(make_req(mmra_pkg::OP_RECEIVE, mmra_pkg::PacketLength, 8'h00,
                          -16'sd1, 16'sd1));
    send_request(make_req(mmra_pkg::OP_COMMIT, mmra_pkg::PacketLength, 8'h00,
                          -16'sd1, 16'sd1));
  endtask

  task automatic test_unused_op();
    send_request(make_req(mmra_pkg::OP_RECEIVE, mmra_pkg::PacketLength, 8'h81,
                          16'sd100, -16'sd100));
    send_request(make_req(OpUnused, mmra_pkg::PacketLength, 8'h00, DeltaMax, DeltaMin));
    send_request(make_req(OpUnused, 6'd63, 8'hff, DeltaMin, DeltaMax));
    send_request(make_req(mmra_pkg::OP_TAKE_WAKEUP, '0, '0, '0, '0));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct = 59;
    test_length_filter();
    test_buttons_and_wakeup();
    test_commit_and_clamp();
    test_unused_op();
    test_random_traffic(170);

    send_idle_pct = 59;
    recv_idle_pct = 38;
    test_random_traffic(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(160);

    req_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests and %0d reports: %0d dropped packets, %0d wakeups taken,",
             requests_sent, reports_checked, drops_seen, wakeups_seen);
    $display("%0d saturating sum updates, three idle mixes; %0d mismatches",
             saturations_seen, mismatches);
    if (mismatches == 0) begin
      $display("mouse_motion_report_accumulator regression: pass");
    end else begin
      $display("mouse_motion_report_accumulator regression: fail");
    end
    $finish;
  end

endmodule
